// ===== hw/rtl/audio_block_mixer_peak_limiter_defines.svh =====
// Assertion macros shared by the mixer RTL files.
// Include this header in any module body that carries assertions; it has no dependencies.
`ifndef AUDIO_BLOCK_MIXER_PEAK_LIMITER_DEFINES_SVH
`define AUDIO_BLOCK_MIXER_PEAK_LIMITER_DEFINES_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define MIXLIM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mixer assertion failed");
// Checked on every clock edge, reset included.
`define MIXLIM_ASSERT_NR(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("mixer assertion failed");
`else
`define MIXLIM_ASSERT(lbl, prop)
`define MIXLIM_ASSERT_NR(lbl, prop)
`endif

`endif

// ===== hw/rtl/mixlim_pkg.sv =====
// Shared types, constants and helpers for the block mixer with peak limiter.
// No dependencies; the front end, divider, back end and top level import this package.
package mixlim_pkg;

   localparam int BLOCK_DEPTH_DEF = 64;
   localparam int ACC_WIDTH_DEF   = 21;

   localparam int SCALED_W = 17;
   localparam int QUOT_W   = 16;

   localparam logic [16:0] VOL_UNITY = 17'd65536;
   localparam logic [1:0]  CH_MONO   = 2'd1;
   localparam logic        CMD_MIX    = 1'b0;
   localparam logic        CMD_FINISH = 1'b1;

   localparam logic [1:0] REG_OUT_CHANNELS    = 2'd0;
   localparam logic [1:0] REG_BLOCK_FRAMES    = 2'd1;
   localparam logic [1:0] REG_LIMIT_THRESHOLD = 2'd2;

   localparam logic [1:0]  RST_OUT_CHANNELS    = 2'd2;
   localparam logic [6:0]  RST_BLOCK_FRAMES    = 7'd64;
   localparam logic [19:0] RST_LIMIT_THRESHOLD = 20'd31130;

   typedef struct packed {
      logic               command;
      logic [5:0]         frame_slot;
      logic [1:0]         in_channels;
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
      logic [16:0]        volume;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] out_left;
      logic signed [15:0] out_right;
      logic [5:0]         frame_number;
      logic               last;
      logic               limited;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  out_channels;
      logic [6:0]  block_frames;
      logic [19:0] limit_threshold;
   } cfg_type;

   // One queued operation: a finish, or a mix with its scaled addends.
   typedef struct packed {
      logic                       finish;
      logic                       wr_right;
      logic [5:0]                 slot;
      logic signed [SCALED_W-1:0] add_left;
      logic signed [SCALED_W-1:0] add_right;
   } mix_op_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MIX_WR,
      ST_SCAN,
      ST_SCAN_END,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_DIV,
      ST_EMIT_OUT
   } back_state_type;

   function automatic logic [6:0] frames_used(input logic [6:0] bf, input logic [6:0] depth);
      logic [6:0] n;
      n = bf;
      if (bf == 7'd0) n = 7'd1;
      else if (bf > depth) n = depth;
      return n;
   endfunction

endpackage

// ===== hw/rtl/mixlim_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mixlim_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/mixlim_front.sv =====
// Front end: accepts input words, applies volume and channel conversion, and
// queues mix and finish operations for the back end. Uses mixlim_pkg.
module mixlim_front #(
   parameter int BLOCK_DEPTH = mixlim_pkg::BLOCK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mixlim_pkg::req_word_type req_word,
   input  mixlim_pkg::cfg_type      cfg,
   input  logic                     hold,
   output logic                     q_valid,
   output mixlim_pkg::mix_op_type   q_head,
   input  logic                     q_pop
);
   import mixlim_pkg::*;
   `include "audio_block_mixer_peak_limiter_defines.svh"

   logic [16:0]        vol_c;
   logic [6:0]         n_eff;
   logic               in_stereo;
   logic               out_stereo;
   logic signed [16:0] pair_sum;
   logic signed [15:0] op_l;
   logic signed [15:0] op_r;
   logic signed [33:0] prod_l;
   logic signed [33:0] prod_r;
   logic               accept;
   logic               push;
   mix_op_type         entry;

   mix_op_type q_mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   // Product magnitude shifted down by 16, sign restored: truncation toward zero.
   function automatic logic signed [SCALED_W-1:0] shrink(input logic signed [33:0] p);
      logic [33:0]         m;
      logic [SCALED_W-1:0] mg;
      m  = p[33] ? 34'(-p) : p;
      mg = m[32:16];
      return p[33] ? SCALED_W'(-mg) : mg;
   endfunction

   assign vol_c      = (req_word.volume > VOL_UNITY) ? VOL_UNITY : req_word.volume;
   assign n_eff      = frames_used(cfg.block_frames, 7'(BLOCK_DEPTH));
   assign in_stereo  = req_word.in_channels != CH_MONO;
   assign out_stereo = cfg.out_channels != CH_MONO;
   assign pair_sum   = 17'(req_word.sample_left) + 17'(req_word.sample_right);
   assign op_l       = (in_stereo && !out_stereo) ? pair_sum[16:1] : req_word.sample_left;
   assign op_r       = in_stereo ? req_word.sample_right : req_word.sample_left;
   assign prod_l     = op_l * $signed({1'b0, vol_c});
   assign prod_r     = op_r * $signed({1'b0, vol_c});

   always_comb begin
      entry.finish    = req_word.command == CMD_FINISH;
      entry.wr_right  = out_stereo;
      entry.slot      = req_word.frame_slot;
      entry.add_left  = shrink(prod_l);
      entry.add_right = shrink(prod_r);
   end

   assign req_stall = hold || (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   // A mix word for a slot outside the block is taken and dropped.
   assign push      = accept && ((req_word.command == CMD_FINISH) ||
                                 ({1'b0, req_word.frame_slot} < n_eff));

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = q_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wp_ff] <= entry;
      end
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_head  = q_mem_ff[rp_ff];

   `MIXLIM_ASSERT(a_pop_nonempty, q_pop |-> (cnt_ff != 2'd0))
   `MIXLIM_ASSERT_NR(a_cnt_bound, reset || (cnt_ff <= 2'd2))
   `MIXLIM_ASSERT(a_push_lands, (push && !q_pop) |=> (cnt_ff != 2'd0))
endmodule

// ===== hw/rtl/mixlim_div.sv =====
// Restoring divider for the limiter gain: quotient of mag*32768 by the peak,
// one quotient bit per cycle. Uses mixlim_pkg.
module mixlim_div #(
   parameter int ACC_WIDTH = mixlim_pkg::ACC_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ACC_WIDTH-1:0]          mag,
   input  logic [ACC_WIDTH-1:0]          den,
   output logic                          busy,
   output logic [mixlim_pkg::QUOT_W-1:0] quot
);
   import mixlim_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic [ACC_WIDTH-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    sh_ff, sh_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [ACC_WIDTH:0]   trial;
   logic [ACC_WIDTH:0]   diff;
   logic                 ge;

   // The quotient never exceeds 32768, so the top of the dividend, mag >> 1,
   // is already below the divisor and only the low 16 dividend bits need steps.
   assign trial = {rem_ff, sh_ff[QUOT_W-1]};
   assign ge    = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, mag[ACC_WIDTH-1:1]};
         sh_in   = {mag[0], {(QUOT_W-1){1'b0}}};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[ACC_WIDTH-1:0] : trial[ACC_WIDTH-1:0];
         sh_in  = {sh_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign busy = busy_ff;
   assign quot = sh_ff;
endmodule

// ===== hw/rtl/mixlim_back.sv =====
// Back end: owns the mix stores, does the read-modify-write of mix operations,
// and on finish scans for the peak, limits, emits and clears the block.
// Uses mixlim_pkg, mixlim_ram and mixlim_div.
module mixlim_back #(
   parameter int BLOCK_DEPTH = mixlim_pkg::BLOCK_DEPTH_DEF,
   parameter int ACC_WIDTH   = mixlim_pkg::ACC_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mixlim_pkg::cfg_type      cfg,
   input  logic                     q_valid,
   input  mixlim_pkg::mix_op_type   q_head,
   output logic                     q_pop,
   output logic                     init_busy,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mixlim_pkg::rsp_word_type rsp_word
);
   import mixlim_pkg::*;
   `include "audio_block_mixer_peak_limiter_defines.svh"

   localparam int A     = ACC_WIDTH;
   localparam int IDX_W = BLOCK_DEPTH > 1 ? $clog2(BLOCK_DEPTH) : 1;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [A-1:0]     peak_ff, peak_in;
   logic             rescale_ff, rescale_in;
   logic             init_ff, init_in;
   mix_op_type       op_ff, op_in;
   logic [A-1:0]     samp_l_ff, samp_l_in;
   logic [A-1:0]     samp_r_ff, samp_r_in;
   rsp_word_type     rsp_ff, rsp_in;

   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             we_left;
   logic             we_right;
   logic [A-1:0]     wd_left;
   logic [A-1:0]     wd_right;
   logic [A-1:0]     rd_l;
   logic [A-1:0]     rd_r;
   logic             div_start;
   logic             busy_l;
   logic             busy_r;
   logic [QUOT_W-1:0] quot_l;
   logic [QUOT_W-1:0] quot_r;

   logic [6:0]   n_eff;
   logic         out_stereo;
   logic         at_last_frame;
   logic         at_end;
   logic [A-1:0] cand_l;
   logic [A-1:0] cand_r;

   function automatic logic [A-1:0] mag_of(input logic [A-1:0] v);
      return v[A-1] ? A'((~v) + A'(1)) : v;
   endfunction

   function automatic logic [A-1:0] sat_add(input logic [A-1:0] a,
                                            input logic signed [SCALED_W-1:0] b);
      logic signed [A:0] s;
      logic [A-1:0]      r;
      s = $signed({a[A-1], a}) + (A+1)'(b);
      r = s[A-1:0];
      if (s[A] != s[A-1]) begin
         r = s[A] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [15:0] limit16(input logic [A-1:0] v, input logic rs,
                                           input logic [QUOT_W-1:0] q);
      logic [15:0] r;
      if (rs) begin
         if (v[A-1]) r = 16'(-q);
         else r = q[15] ? 16'h7FFF : q;
      end else if (!v[A-1] && (v[A-2:15] != '0)) begin
         r = 16'h7FFF;
      end else if (v[A-1] && !(&v[A-2:15])) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign n_eff         = frames_used(cfg.block_frames, 7'(BLOCK_DEPTH));
   assign out_stereo    = cfg.out_channels != CH_MONO;
   assign at_last_frame = (7'(idx_ff) + 7'd1) == n_eff;
   assign at_end        = idx_ff == IDX_W'(BLOCK_DEPTH - 1);
   assign cand_l        = mag_of(rd_l);
   assign cand_r        = out_stereo ? mag_of(rd_r) : '0;

   mixlim_ram #(.WIDTH(A), .DEPTH(BLOCK_DEPTH)) u_store_left (
      .clock   (clock),
      .wr_en   (we_left),
      .wr_addr (wr_addr),
      .wr_data (wd_left),
      .rd_addr (rd_addr),
      .rd_data (rd_l)
   );

   mixlim_ram #(.WIDTH(A), .DEPTH(BLOCK_DEPTH)) u_store_right (
      .clock   (clock),
      .wr_en   (we_right),
      .wr_addr (wr_addr),
      .wr_data (wd_right),
      .rd_addr (rd_addr),
      .rd_data (rd_r)
   );

   mixlim_div #(.ACC_WIDTH(A)) u_div_left (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (mag_of(rd_l)),
      .den   (peak_ff),
      .busy  (busy_l),
      .quot  (quot_l)
   );

   mixlim_div #(.ACC_WIDTH(A)) u_div_right (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (mag_of(rd_r)),
      .den   (peak_ff),
      .busy  (busy_r),
      .quot  (quot_r)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP:     if (at_end) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid) state_in = q_head.finish ? ST_SCAN : ST_MIX_WR;
         end
         ST_MIX_WR:    state_in = ST_IDLE;
         ST_SCAN:      if (at_last_frame) state_in = ST_SCAN_END;
         ST_SCAN_END:  state_in = ST_EMIT_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_LOAD;
         ST_EMIT_LOAD: state_in = ST_EMIT_DIV;
         ST_EMIT_DIV:  if (!rescale_ff || !(busy_l || busy_r)) state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (!rsp_stall) begin
               if (at_end) state_in = ST_IDLE;
               else if (at_last_frame) state_in = ST_SWEEP;
               else state_in = ST_EMIT_RD;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs to the stores, the queue, the dividers and the result port.
   always_comb begin
      q_pop     = 1'b0;
      rd_addr   = idx_ff;
      wr_addr   = idx_ff;
      we_left   = 1'b0;
      we_right  = 1'b0;
      wd_left   = '0;
      wd_right  = '0;
      div_start = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            we_left  = 1'b1;
            we_right = 1'b1;
         end
         ST_IDLE: begin
            q_pop   = q_valid;
            rd_addr = q_head.slot[IDX_W-1:0];
         end
         ST_MIX_WR: begin
            wr_addr  = op_ff.slot[IDX_W-1:0];
            we_left  = 1'b1;
            we_right = op_ff.wr_right;
            wd_left  = sat_add(rd_l, op_ff.add_left);
            wd_right = sat_add(rd_r, op_ff.add_right);
         end
         ST_EMIT_LOAD: div_start = rescale_ff;
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            we_left   = !rsp_stall;
            we_right  = !rsp_stall;
         end
         ST_SCAN, ST_SCAN_END, ST_EMIT_RD, ST_EMIT_DIV: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      peak_in    = peak_ff;
      rescale_in = rescale_ff;
      init_in    = init_ff;
      op_in      = op_ff;
      samp_l_in  = samp_l_ff;
      samp_r_in  = samp_r_ff;
      rsp_in     = rsp_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (at_end) init_in = 1'b0;
            else idx_in = IDX_W'(idx_ff + 1'b1);
         end
         ST_IDLE: begin
            op_in   = q_head;
            idx_in  = '0;
            pend_in = 1'b0;
            peak_in = '0;
         end
         ST_SCAN, ST_SCAN_END: begin
            // Read data trails the address, as the store read port is registered.
            if (pend_ff) begin
               if (cand_l > peak_in) peak_in = cand_l;
               if (cand_r > peak_in) peak_in = cand_r;
            end
            if (state_ff == ST_SCAN) begin
               pend_in = 1'b1;
               if (!at_last_frame) idx_in = IDX_W'(idx_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
               idx_in  = '0;
            end
         end
         ST_EMIT_RD: rescale_in = 33'(peak_ff) > 33'(cfg.limit_threshold);
         ST_EMIT_LOAD: begin
            samp_l_in = rd_l;
            samp_r_in = rd_r;
         end
         ST_EMIT_DIV: begin
            rsp_in.out_left     = limit16(samp_l_ff, rescale_ff, quot_l);
            rsp_in.out_right    = out_stereo ? limit16(samp_r_ff, rescale_ff, quot_r) : '0;
            rsp_in.frame_number = 6'(idx_ff);
            rsp_in.last         = at_last_frame;
            rsp_in.limited      = rescale_ff;
         end
         ST_EMIT_OUT: begin
            if (!rsp_stall && !at_end) idx_in = IDX_W'(idx_ff + 1'b1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff    <= peak_in;
      rescale_ff <= rescale_in;
      op_ff      <= op_in;
      samp_l_ff  <= samp_l_in;
      samp_r_ff  <= samp_r_in;
      rsp_ff     <= rsp_in;
   end

   assign init_busy = init_ff;
   assign rsp_word  = rsp_ff;

   `MIXLIM_ASSERT(a_scan_no_write, (state_ff == ST_SCAN) |-> !we_left)
   `MIXLIM_ASSERT(a_pop_in_idle, q_pop |-> (state_ff == ST_IDLE))
   `MIXLIM_ASSERT(a_mix_two_cycles, (state_ff == ST_MIX_WR) |=> (state_ff == ST_IDLE))
endmodule

// ===== hw/rtl/audio_block_mixer_peak_limiter.sv =====
// Block mixer with peak limiter. In the back end a mix word takes a store
// read, then an add and write back; a two-word queue lets the input keep
// accepting while the back end works. A finish word scans the block for its
// peak, then emits each frame in turn (store read, load, a wait on the
// 16-step gain divider when the block is rescaled, output), and then clears
// the rest of the store at one entry a cycle. After reset a clearing pass
// over all BLOCK_DEPTH entries runs before the first word is taken.
module audio_block_mixer_peak_limiter #(
   parameter int BLOCK_DEPTH = mixlim_pkg::BLOCK_DEPTH_DEF,
   parameter int ACC_WIDTH   = mixlim_pkg::ACC_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mixlim_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mixlim_pkg::rsp_word_type rsp_word,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import mixlim_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic       q_valid;
   logic       q_pop;
   logic       init_busy;
   mix_op_type q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_OUT_CHANNELS:    cfg_in.out_channels    = pwdata[1:0];
            REG_BLOCK_FRAMES:    cfg_in.block_frames    = pwdata[6:0];
            REG_LIMIT_THRESHOLD: cfg_in.limit_threshold = pwdata[19:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_OUT_CHANNELS:    prdata = 32'(cfg_ff.out_channels);
         REG_BLOCK_FRAMES:    prdata = 32'(cfg_ff.block_frames);
         REG_LIMIT_THRESHOLD: prdata = 32'(cfg_ff.limit_threshold);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_channels    <= RST_OUT_CHANNELS;
         cfg_ff.block_frames    <= RST_BLOCK_FRAMES;
         cfg_ff.limit_threshold <= RST_LIMIT_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mixlim_front #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .hold      (init_busy),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   mixlim_back #(.BLOCK_DEPTH(BLOCK_DEPTH), .ACC_WIDTH(ACC_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );
endmodule

// ===== bench/audio_block_mixer_peak_limiter_tb.sv =====
// Self-checking bench for the block mixer with peak limiter: random and directed
// words against a built-in predictor. Depends on mixlim_pkg and the block's RTL.
module audio_block_mixer_peak_limiter_tb;
   import mixlim_pkg::*;

   localparam int DEPTH     = 64;
   localparam int IDLE_PCT  = 9;
   localparam int STALL_MAX = 3000;
   localparam int REQ_W     = $bits(req_word_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   audio_block_mixer_peak_limiter dut (.*);

   req_word_type pending_words[$];
   rsp_word_type expected_frames[$];
   longint       mix_left[DEPTH];
   longint       mix_right[DEPTH];
   logic [1:0]   out_ch_cfg = RST_OUT_CHANNELS;
   logic [6:0]   frames_cfg = RST_BLOCK_FRAMES;
   logic [19:0]  thresh_cfg = RST_LIMIT_THRESHOLD;
   int           errors = 0;
   int           cycle_count = 0;
   int           quiet_cycles = 0;
   logic         req_taken = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Idling is switched off for a stretch in the middle of the run.
   function automatic bit idle_now();
      return !(cycle_count > 3000 && cycle_count < 4500) && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic int block_len();
      if (frames_cfg == 7'd0) return 1;
      if (frames_cfg > DEPTH) return DEPTH;
      return frames_cfg;
   endfunction

   function automatic longint sat_acc(longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048576) return -1048576;
      return v;
   endfunction

   function automatic longint apply_gain(longint s, longint vol);
      longint p, m;
      p = s * vol;
      m = (p < 0 ? -p : p) >> 16;
      return p < 0 ? -m : m;
   endfunction

   function automatic longint limit_value(longint v, bit rescale, longint peak);
      if (rescale) v = (v * 32768) / peak;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic predict_word(req_word_type w);
      int           n, k;
      bit           out_st, in_st, rescale;
      longint       l, r, vol, s, peak, a;
      rsp_word_type f;
      n = block_len();
      out_st = (out_ch_cfg != CH_MONO);
      if (w.command == CMD_MIX) begin
         in_st = (w.in_channels != CH_MONO);
         l = w.sample_left;
         r = w.sample_right;
         vol = (w.volume > VOL_UNITY) ? 65536 : w.volume;
         if (w.frame_slot >= n) return;
         if (!in_st && out_st) begin
            s = apply_gain(l, vol);
            mix_left[w.frame_slot] = sat_acc(mix_left[w.frame_slot] + s);
            mix_right[w.frame_slot] = sat_acc(mix_right[w.frame_slot] + s);
         end else if (in_st && !out_st) begin
            s = apply_gain((l + r) >>> 1, vol);
            mix_left[w.frame_slot] = sat_acc(mix_left[w.frame_slot] + s);
         end else begin
            mix_left[w.frame_slot] = sat_acc(mix_left[w.frame_slot] + apply_gain(l, vol));
            if (in_st)
               mix_right[w.frame_slot] =
                  sat_acc(mix_right[w.frame_slot] + apply_gain(r, vol));
         end
         return;
      end
      peak = 0;
      for (k = 0; k < n; k++) begin
         a = mix_left[k] < 0 ? -mix_left[k] : mix_left[k];
         if (a > peak) peak = a;
         if (out_st) begin
            a = mix_right[k] < 0 ? -mix_right[k] : mix_right[k];
            if (a > peak) peak = a;
         end
      end
      rescale = peak > longint'(thresh_cfg);
      for (k = 0; k < n; k++) begin
         f.out_left = 16'(limit_value(mix_left[k], rescale, peak));
         f.out_right = out_st ? 16'(limit_value(mix_right[k], rescale, peak)) : 16'd0;
         f.frame_number = 6'(k);
         f.last = (k + 1 == n);
         f.limited = rescale;
         expected_frames.push_back(f);
      end
      for (k = 0; k < DEPTH; k++) begin
         mix_left[k] = 0;
         mix_right[k] = 0;
      end
   endtask

   // Driver: a word stays on the bus until it is taken.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_words.size() != 0 && !idle_now()) begin
            req_valid <= 1'b1;
            req_word <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= idle_now();
   end

   // Monitor: predicts on every accepted input word and checks every frame.
   always @(posedge clock) begin
      rsp_word_type e;
      bit           took_in;
      bit           took_out;
      took_in  = !reset && req_valid && !req_stall;
      took_out = !reset && rsp_valid && !rsp_stall;
      cycle_count <= cycle_count + 1;
      req_taken <= took_in;
      if (!reset) begin
         if (took_in || took_out) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (took_in) begin
            predict_word(req_word);
         end
         if (took_out) begin
            if (expected_frames.size() == 0) begin
               $error("unexpected frame %p", rsp_word);
               errors++;
            end else begin
               e = expected_frames.pop_front();
               if (rsp_word.out_left !== e.out_left) begin
                  $error("out_left exp %0d got %0d", e.out_left, rsp_word.out_left);
                  errors++;
               end
               if (rsp_word.out_right !== e.out_right) begin
                  $error("out_right exp %0d got %0d", e.out_right, rsp_word.out_right);
                  errors++;
               end
               if (rsp_word.frame_number !== e.frame_number) begin
                  $error("frame_number exp %0d got %0d", e.frame_number,
                         rsp_word.frame_number);
                  errors++;
               end
               if (rsp_word.last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_word.last);
                  errors++;
               end
               if (rsp_word.limited !== e.limited) begin
                  $error("limited exp %0d got %0d", e.limited, rsp_word.limited);
                  errors++;
               end
            end
         end
         if (quiet_cycles >= STALL_MAX) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 4'(index) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_OUT_CHANNELS: out_ch_cfg = value[1:0];
         REG_BLOCK_FRAMES: frames_cfg = value[6:0];
         default: thresh_cfg = value[19:0];
      endcase
   endtask

   task automatic configure(logic [1:0] och, logic [6:0] frames, logic [19:0] thresh);
      csr_write(REG_OUT_CHANNELS, 32'(och));
      csr_write(REG_BLOCK_FRAMES, 32'(frames));
      csr_write(REG_LIMIT_THRESHOLD, 32'(thresh));
   endtask

   task automatic add_mix(int slot, logic [1:0] ich, int l, int r, int vol);
      req_word_type w;
      w.command = CMD_MIX;
      w.frame_slot = 6'(slot);
      w.in_channels = ich;
      w.sample_left = 16'(l);
      w.sample_right = 16'(r);
      w.volume = 17'(vol);
      pending_words.push_back(w);
   endtask

   task automatic add_finish();
      req_word_type w;
      w = req_word_type'(REQ_W'({$urandom, $urandom}));
      w.command = CMD_FINISH;
      pending_words.push_back(w);
   endtask

   // The sender holds off until the block is drained, then allows for the
   // clearing of the rest of the store before any register write.
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_frames.size() != 0)
         @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      int i, n, cnt;
      bit loud;
      logic [1:0] och;
      logic [6:0] frames;
      logic [19:0] thresh;
      for (i = 0; i < DEPTH; i++) begin
         mix_left[i] = 0;
         mix_right[i] = 0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: extremes of samples, volume and slots, odd channel codes.
      add_mix(0, CH_MONO, -32768, 0, 65536);
      add_mix(63, 2'd2, 32767, -32768, 65536);
      add_mix(5, 2'd0, 12345, -23456, 131071);
      add_mix(6, 2'd3, -1, 1, 0);
      add_mix(7, 2'd2, -32768, 32767, 98304);
      add_finish();
      drain();

      // Mono output, one-frame block, limiting at any nonzero peak.
      configure(CH_MONO, 7'd0, 20'd0);
      add_mix(0, 2'd2, -32767, -32768, 65536);
      add_mix(0, 2'd2, -3, 0, 65535);
      add_mix(1, CH_MONO, 32767, 0, 65536);
      add_mix(0, CH_MONO, 1000, 32767, 40000);
      add_finish();
      drain();

      // Oversized block, saturating sums whose peak just passes the threshold.
      configure(2'd3, 7'd127, 20'hFFFFF);
      for (i = 0; i < 34; i++) add_mix(2, 2'd2, 32767, -32768, 65536);
      add_mix(3, CH_MONO, 20000, 0, 65536);
      add_mix(3, CH_MONO, 20000, 0, 65536);
      add_finish();
      drain();

      cnt = 0;
      while (cnt < 112) begin
         och = 2'($urandom_range(3));
         case ($urandom_range(7))
            0: frames = 7'd64;
            1: frames = $urandom_range(1) ? 7'd0 : 7'd127;
            default: frames = 7'($urandom_range(1, 8));
         endcase
         case ($urandom_range(3))
            0: thresh = 20'd0;
            1: thresh = 20'hFFFFF;
            default: thresh = 20'($urandom_range(0, 70000));
         endcase
         configure(och, frames, thresh);
         n = block_len();
         loud = ($urandom_range(3) == 0);
         for (i = $urandom_range(4, 14); i > 0; i--) begin
            add_mix($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(n - 1),
                    2'($urandom_range(3)),
                    loud ? ($urandom_range(1) ? 32767 : -32768) : int'($urandom),
                    loud ? ($urandom_range(1) ? 32767 : -32768) : int'($urandom),
                    loud ? 65536 : $urandom_range(131071));
            cnt++;
         end
         add_finish();
         cnt++;
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mixlim_pkg.sv
hw/rtl/mixlim_ram.sv
hw/rtl/mixlim_front.sv
hw/rtl/mixlim_div.sv
hw/rtl/mixlim_back.sv
hw/rtl/audio_block_mixer_peak_limiter.sv
bench/audio_block_mixer_peak_limiter_tb.sv
